@@ hw/rtl/tcdec_pkg.sv @@
// shared types, character codes and sizes for the text command decoder
package tcdec_pkg;

  // line length limit and derived width
  localparam int LINE_CHARS = 31;
  localparam int LEN_W      = $clog2(LINE_CHARS + 1);

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // field widths
  localparam int EN_W   = 5;
  localparam int THR_W  = 8;
  localparam int CTRL_W = 17;

  localparam logic [THR_W-1:0] DEF_THR_RESET = 8'd80;
  localparam logic [8:0]       THR_MAX       = 9'd255;
  localparam logic [8:0]       THR_SAT       = 9'd256;

  // prefix lengths and keyword text, first character in the top byte
  localparam int PREFIX_LEN    = 4;
  localparam int TH_PREFIX_LEN = 2;
  localparam logic [31:0] STR_SRC0 = "SRC0";
  localparam logic [31:0] STR_SRC1 = "SRC1";
  localparam logic [31:0] STR_FILL = "FILL";
  localparam logic [15:0] STR_TH   = "TH";

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_BITS    = 3'd0,
    KIND_SRC0    = 3'd1,
    KIND_SRC1    = 3'd2,
    KIND_THR     = 3'd3,
    KIND_FILL    = 3'd4,
    KIND_UNKNOWN = 3'd5
  } cmd_kind_t;

  // threshold number parser phases
  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } thr_phase_t;

  // one classified line
  typedef struct packed {
    cmd_kind_t         kind;
    logic [EN_W-1:0]   en;
    logic [THR_W-1:0]  thr;
  } cmd_t;

endpackage

@@ hw/rtl/text_command_control_word_decoder_unit.sv @@
// top level of the text command control word decoder
//
// usage:
//   input side is a queue: drive in_rx_byte with one received character and
//   raise in_push; the beat is taken at a clock edge with in_full low.
//   each byte, also the cr or lf that ends a line, is one beat:
//   commands are recognised as the bytes arrive, so a line end needs no walk
//   over stored text
//   result side is a queue too: while out_empty is low, out_ctrl_word and
//   out_cmd_kind hold the oldest result; out_pop takes the beat
//   a non-empty line gives one result: it is queued on its line end beat and
//   moved into the output register at an edge where that register is free
//   if the receiver stalls, up to two line results wait in the command queue
//   plus one in the output register; only then does in_full rise
//   cfg_default_threshold is written when cfg_valid is high (cfg_ready is
//   always high); write it only while the block is idle
//   synchronous reset: line cleared, control word back to threshold 80 with
//   enables and source zero, default threshold 80, both queues empty
module text_command_control_word_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // byte input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [16:0] out_ctrl_word,
  output logic [2:0]  out_cmd_kind,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_default_threshold
);
  import tcdec_pkg::*;

  logic [THR_W-1:0] def_thr_r;
  logic             in_accept;
  logic             cmd_push, q_full, q_empty, q_pop;
  cmd_t             cmd_in, cmd_out;
  logic             res_valid;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_thr_r <= DEF_THR_RESET;
    end else if (cfg_valid) begin
      def_thr_r <= cfg_default_threshold;
    end
  end

  // a byte beat stalls only when the command queue has no room
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // front: line tracking and on-the-fly command recognition
  tcdec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .rx_byte  (in_rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // queue decoupling recognition from control word update
  tcdec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (cmd_out)
  );

  // back: control word update and result register
  tcdec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .def_thr   (def_thr_r),
    .q_empty   (q_empty),
    .q_cmd     (cmd_out),
    .q_pop     (q_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res_ctrl  (out_ctrl_word),
    .res_kind  (out_cmd_kind)
  );

  assign out_empty = !res_valid;

endmodule

@@ hw/rtl/tcdec_front.sv @@
// front end: takes bytes, recognises commands on the fly, queues a command per non-empty line
module tcdec_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [7:0]                     rx_byte,
  output logic                           cmd_push,
  output tcdec_pkg::cmd_t                cmd
);
  import tcdec_pkg::*;

  logic [LEN_W-1:0] line_len_r, line_len_nxt;
  logic [LEN_W-1:0] text_len_r, text_len_nxt;
  logic             nul_seen_r, nul_seen_nxt;
  logic             bits_end_r, bits_end_nxt;
  logic             bits_fail_r, bits_fail_nxt;
  logic [2:0]       bits_n_r, bits_n_nxt;
  logic [EN_W-1:0]  bits_v_r, bits_v_nxt;
  logic             m_src0_r, m_src0_nxt;
  logic             m_src1_r, m_src1_nxt;
  logic             m_fill_r, m_fill_nxt;
  logic             m_th_r, m_th_nxt;
  thr_phase_t       ph_r, ph_nxt;
  logic             th_neg_r, th_neg_nxt;
  logic [8:0]       th_val_r, th_val_nxt;

  logic             is_eol, do_store, is_text, th_text;
  logic             is_digit, is_ws, is_sign;
  logic [3:0]       dval;
  logic [11:0]      th_mac;
  logic [1:0]       pidx;
  logic             th_pidx;
  logic             in_prefix, in_th_prefix;
  logic [THR_W-1:0] thr_final;

  assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign do_store = accept && !is_eol && (line_len_r < LEN_W'(LINE_CHARS));
  // bytes after the first nul are counted but not matched
  assign is_text  = do_store && !nul_seen_r && (rx_byte != CH_NUL);
  assign th_text  = is_text && (text_len_r >= LEN_W'(TH_PREFIX_LEN));

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign dval     = rx_byte[3:0];
  assign th_mac   = {th_val_r, 3'b000} + {2'b00, th_val_r, 1'b0} + {8'b0, dval};

  assign in_prefix    = text_len_r < LEN_W'(PREFIX_LEN);
  assign in_th_prefix = text_len_r < LEN_W'(TH_PREFIX_LEN);
  assign pidx         = 2'd3 - text_len_r[1:0];
  assign th_pidx      = ~text_len_r[0];

  // line counters and keyword matchers
  always_comb begin
    line_len_nxt = line_len_r;
    text_len_nxt = text_len_r;
    nul_seen_nxt = nul_seen_r;
    m_src0_nxt   = m_src0_r;
    m_src1_nxt   = m_src1_r;
    m_fill_nxt   = m_fill_r;
    m_th_nxt     = m_th_r;
    if (do_store) begin
      line_len_nxt = line_len_r + LEN_W'(1);
      if (rx_byte == CH_NUL) begin
        nul_seen_nxt = 1'b1;
      end
    end
    if (is_text) begin
      text_len_nxt = text_len_r + LEN_W'(1);
      if (in_prefix) begin
        if (rx_byte != STR_SRC0[{pidx, 3'b000} +: 8]) m_src0_nxt = 1'b0;
        if (rx_byte != STR_SRC1[{pidx, 3'b000} +: 8]) m_src1_nxt = 1'b0;
        if (rx_byte != STR_FILL[{pidx, 3'b000} +: 8]) m_fill_nxt = 1'b0;
      end
      if (in_th_prefix && (rx_byte != STR_TH[{th_pidx, 3'b000} +: 8])) begin
        m_th_nxt = 1'b0;
      end
    end
    if (accept && is_eol) begin
      line_len_nxt = '0;
      text_len_nxt = '0;
      nul_seen_nxt = 1'b0;
      m_src0_nxt   = 1'b1;
      m_src1_nxt   = 1'b1;
      m_fill_nxt   = 1'b1;
      m_th_nxt     = 1'b1;
    end
  end

  // enable bit string, lsb first, ended by a space
  always_comb begin
    bits_end_nxt  = bits_end_r;
    bits_fail_nxt = bits_fail_r;
    bits_n_nxt    = bits_n_r;
    bits_v_nxt    = bits_v_r;
    if (is_text && !bits_end_r && !bits_fail_r) begin
      if (rx_byte == CH_SPACE) begin
        bits_end_nxt = 1'b1;
      end else if (((rx_byte != CH_ZERO) && (rx_byte != CH_ONE)) || (bits_n_r == 3'(EN_W))) begin
        bits_fail_nxt = 1'b1;
      end else begin
        bits_v_nxt[bits_n_r] = rx_byte[0];
        bits_n_nxt           = bits_n_r + 3'd1;
      end
    end
    if (accept && is_eol) begin
      bits_end_nxt  = 1'b0;
      bits_fail_nxt = 1'b0;
      bits_n_nxt    = '0;
      bits_v_nxt    = '0;
    end
  end

  // threshold parser phase
  always_comb begin
    ph_nxt = ph_r;
    if (th_text) begin
      unique case (ph_r)
        PH_SKIP: begin
          if (is_sign || is_digit) ph_nxt = PH_DIGITS;
          else if (!is_ws)         ph_nxt = PH_DONE;
        end
        PH_DIGITS: begin
          if (!is_digit) ph_nxt = PH_DONE;
        end
        default: ph_nxt = PH_DONE;
      endcase
    end
    if (accept && is_eol) ph_nxt = PH_SKIP;
  end

  // threshold parser value, saturated just above the top of range
  always_comb begin
    th_neg_nxt = th_neg_r;
    th_val_nxt = th_val_r;
    if (th_text) begin
      unique case (ph_r)
        PH_SKIP: begin
          if (is_sign)       th_neg_nxt = (rx_byte == CH_MINUS);
          else if (is_digit) th_val_nxt = {5'b0, dval};
        end
        PH_DIGITS: begin
          if (is_digit) th_val_nxt = (th_mac > {3'b000, THR_MAX}) ? THR_SAT : th_mac[8:0];
        end
        default: ;
      endcase
    end
    if (accept && is_eol) begin
      th_neg_nxt = 1'b0;
      th_val_nxt = '0;
    end
  end

  // classify in priority order at line end
  assign thr_final = (th_neg_r && (th_val_r != '0)) ? '0 :
                     (th_val_r[8] ? THR_MAX[7:0] : th_val_r[7:0]);

  always_comb begin
    cmd.en   = '0;
    cmd.thr  = thr_final;
    if (!bits_fail_r && (bits_n_r != '0)) begin
      cmd.kind = KIND_BITS;
      cmd.en   = bits_v_r;
    end else if (m_src0_r && !in_prefix) begin
      cmd.kind = KIND_SRC0;
    end else if (m_src1_r && !in_prefix) begin
      cmd.kind = KIND_SRC1;
    end else if (m_th_r && !in_th_prefix && (line_len_r > LEN_W'(TH_PREFIX_LEN))) begin
      cmd.kind = KIND_THR;
    end else if (m_fill_r && !in_prefix) begin
      cmd.kind = KIND_FILL;
    end else begin
      cmd.kind = KIND_UNKNOWN;
    end
  end

  assign cmd_push = accept && is_eol && (line_len_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      text_len_r  <= '0;
      nul_seen_r  <= 1'b0;
      bits_end_r  <= 1'b0;
      bits_fail_r <= 1'b0;
      bits_n_r    <= '0;
      bits_v_r    <= '0;
      m_src0_r    <= 1'b1;
      m_src1_r    <= 1'b1;
      m_fill_r    <= 1'b1;
      m_th_r      <= 1'b1;
      ph_r        <= PH_SKIP;
      th_neg_r    <= 1'b0;
      th_val_r    <= '0;
    end else begin
      line_len_r  <= line_len_nxt;
      text_len_r  <= text_len_nxt;
      nul_seen_r  <= nul_seen_nxt;
      bits_end_r  <= bits_end_nxt;
      bits_fail_r <= bits_fail_nxt;
      bits_n_r    <= bits_n_nxt;
      bits_v_r    <= bits_v_nxt;
      m_src0_r    <= m_src0_nxt;
      m_src1_r    <= m_src1_nxt;
      m_fill_r    <= m_fill_nxt;
      m_th_r      <= m_th_nxt;
      ph_r        <= ph_nxt;
      th_neg_r    <= th_neg_nxt;
      th_val_r    <= th_val_nxt;
    end
  end

endmodule

@@ hw/rtl/tcdec_fifo.sv @@
// short command queue between front and back end
module tcdec_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcdec_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tcdec_pkg::cmd_t pop_data
);
  import tcdec_pkg::*;

  cmd_t                  store_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full     = count_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop)      count_nxt = count_r + FIFO_CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/tcdec_back.sv @@
// back end: applies a queued command to the control word and holds the result
module tcdec_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tcdec_pkg::THR_W-1:0]     def_thr,
  input  logic                            q_empty,
  input  tcdec_pkg::cmd_t                 q_cmd,
  output logic                            q_pop,
  input  logic                            res_pop,
  output logic                            res_valid,
  output logic [tcdec_pkg::CTRL_W-1:0]    res_ctrl,
  output logic [2:0]                      res_kind
);
  import tcdec_pkg::*;

  logic [CTRL_W-1:0] cur_ctrl_r, cur_ctrl_nxt;
  logic [CTRL_W-1:0] res_ctrl_r;
  logic [2:0]        res_kind_r;
  logic              res_valid_r;
  logic              load;

  assign load  = !q_empty && (!res_valid_r || res_pop);
  assign q_pop = load;

  // word layout: source, threshold, three spare zeros, enables
  always_comb begin
    unique case (q_cmd.kind)
      KIND_BITS: cur_ctrl_nxt = {1'b0, def_thr, 3'b000, q_cmd.en};
      KIND_SRC0: cur_ctrl_nxt = {1'b0, def_thr, 3'b000, 5'b00000};
      KIND_SRC1: cur_ctrl_nxt = {1'b1, def_thr, 3'b000, 5'b00000};
      KIND_THR:  cur_ctrl_nxt = {1'b0, q_cmd.thr, 3'b000, 5'b00000};
      KIND_FILL: cur_ctrl_nxt = {1'b1, def_thr, 3'b000, 5'b00000};
      default:   cur_ctrl_nxt = cur_ctrl_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_ctrl_r <= cur_ctrl_nxt;
      res_kind_r <= q_cmd.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      cur_ctrl_r  <= {1'b0, DEF_THR_RESET, 3'b000, 5'b00000};
    end else begin
      if (load) begin
        res_valid_r <= 1'b1;
        cur_ctrl_r  <= cur_ctrl_nxt;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res_ctrl  = res_ctrl_r;
  assign res_kind  = res_kind_r;

endmodule
